[design/gtg_pkg.sv]
// gtg_pkg: shared types, widths, register map and CORDIC arctangent table
// for the go-to-goal velocity controller.
// No dependencies.
package gtg_pkg;

  // Datapath widths
  localparam int OFS_W      = 17;  // goal offset, exact difference of two Q6.10 values
  localparam int XY_W       = 26;  // CORDIC x/y, offset * 64 plus CORDIC gain and headroom
  localparam int Z_W        = 24;  // CORDIC angle accumulator, Q.20 radians
  localparam int ERR_W      = 17;  // heading error, Q4.12
  localparam int MUL_W      = 18;  // shared multiplier operand width
  localparam int PROD_W     = 2 * MUL_W;
  localparam int ANG_PROD_W = 29;  // gain * error never needs more
  localparam int SQ_W       = 32;  // one square of a 17-bit offset or a 16-bit threshold
  localparam int D2_W       = 33;  // sum of two squares

  localparam int ATAN_IDX_W = 5;   // table has 21 entries
  localparam logic signed [Z_W-1:0] HALF_PI_Q20 = 24'sd1647099;

  // Configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam logic [2:0] REG_GOAL_X    = 3'd0;
  localparam logic [2:0] REG_GOAL_Y    = 3'd1;
  localparam logic [2:0] REG_CRUISE    = 3'd2;
  localparam logic [2:0] REG_SLOW_SPD  = 3'd3;
  localparam logic [2:0] REG_SLOW_DIST = 3'd4;
  localparam logic [2:0] REG_STOP_DIST = 3'd5;
  localparam logic [2:0] REG_HEAD_TOL  = 3'd6;
  localparam logic [2:0] REG_GAIN      = 3'd7;

  // Operation selected on the shared multiplier
  typedef enum logic [2:0] {
    MUL_ERR  = 3'd0,
    MUL_DX   = 3'd1,
    MUL_DY   = 3'd2,
    MUL_STOP = 3'd3,
    MUL_SLOW = 3'd4
  } mul_sel_t;

  // Configuration register contents
  typedef struct packed {
    logic signed [15:0] goal_x;
    logic signed [15:0] goal_y;
    logic signed [15:0] cruise_speed;
    logic signed [15:0] slow_speed;
    logic [15:0]        slow_distance;
    logic [15:0]        stop_distance;
    logic [14:0]        heading_tolerance;
    logic [11:0]        steering_gain;
  } gtg_cfg_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic                  load_in;   // capture pose, form goal offset
    logic                  pre_rot;   // load CORDIC with quadrant fold
    logic                  iter_en;   // one vectoring step
    logic [ATAN_IDX_W-1:0] iter_idx;
    logic                  bear_en;   // round bearing, form heading error
    logic                  mul_go;    // issue one multiply
    mul_sel_t              mul_sel;
    logic                  load_out;  // register result and arrival flag
  } gtg_cmd_t;

  // atan(2^-i) in Q.20 radians
  function automatic logic [19:0] atan_q20(input logic [ATAN_IDX_W-1:0] idx);
    logic [19:0] v;
    case (idx)
      5'd0:    v = 20'd823550;
      5'd1:    v = 20'd486170;
      5'd2:    v = 20'd256879;
      5'd3:    v = 20'd130396;
      5'd4:    v = 20'd65451;
      5'd5:    v = 20'd32757;
      5'd6:    v = 20'd16383;
      5'd7:    v = 20'd8192;
      5'd8:    v = 20'd4096;
      5'd9:    v = 20'd2048;
      5'd10:   v = 20'd1024;
      5'd11:   v = 20'd512;
      5'd12:   v = 20'd256;
      5'd13:   v = 20'd128;
      5'd14:   v = 20'd64;
      5'd15:   v = 20'd32;
      5'd16:   v = 20'd16;
      5'd17:   v = 20'd8;
      5'd18:   v = 20'd4;
      5'd19:   v = 20'd2;
      5'd20:   v = 20'd1;
      default: v = 20'd0;
    endcase
    return v;
  endfunction

endpackage

[design/gtg_if.sv]
// gtg_if: request channel interfaces (pose in, velocity command out).
// Plain valid/ready handshake; no dependencies.
interface gtg_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pose_x;
  logic signed [15:0] pose_y;
  logic signed [15:0] pose_heading;

  modport source (output valid, output pose_x, output pose_y, output pose_heading,
                  input ready);
  modport sink   (input valid, input pose_x, input pose_y, input pose_heading,
                  output ready);
endinterface

interface gtg_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] linear_velocity;
  logic signed [15:0] angular_velocity;
  logic               arrived;

  modport source (output valid, output linear_velocity, output angular_velocity,
                  output arrived, input ready);
  modport sink   (input valid, input linear_velocity, input angular_velocity,
                  input arrived, output ready);
endinterface

[design/gtg_regs.sv]
// gtg_regs: APB-style configuration register file.
// Depends on gtg_pkg for the register map and gtg_cfg_t.
module gtg_regs import gtg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output gtg_cfg_t              cfg
);

  gtg_cfg_t   cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg     = cfg_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.goal_x            <= 16'sd0;
      cfg_r.goal_y            <= 16'sd0;
      cfg_r.cruise_speed      <= 16'sd1024;
      cfg_r.slow_speed        <= 16'sd512;
      cfg_r.slow_distance     <= 16'd512;
      cfg_r.stop_distance     <= 16'd102;
      cfg_r.heading_tolerance <= 15'd41;
      cfg_r.steering_gain     <= 12'd512;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_GOAL_X:    cfg_r.goal_x            <= pwdata[15:0];
        REG_GOAL_Y:    cfg_r.goal_y            <= pwdata[15:0];
        REG_CRUISE:    cfg_r.cruise_speed      <= pwdata[15:0];
        REG_SLOW_SPD:  cfg_r.slow_speed        <= pwdata[15:0];
        REG_SLOW_DIST: cfg_r.slow_distance     <= pwdata[15:0];
        REG_STOP_DIST: cfg_r.stop_distance     <= pwdata[15:0];
        REG_HEAD_TOL:  cfg_r.heading_tolerance <= pwdata[14:0];
        REG_GAIN:      cfg_r.steering_gain     <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // Read mux, signed fields sign extended
  always_comb begin
    unique case (reg_idx)
      REG_GOAL_X:    prdata = {{16{cfg_r.goal_x[15]}}, cfg_r.goal_x};
      REG_GOAL_Y:    prdata = {{16{cfg_r.goal_y[15]}}, cfg_r.goal_y};
      REG_CRUISE:    prdata = {{16{cfg_r.cruise_speed[15]}}, cfg_r.cruise_speed};
      REG_SLOW_SPD:  prdata = {{16{cfg_r.slow_speed[15]}}, cfg_r.slow_speed};
      REG_SLOW_DIST: prdata = {16'd0, cfg_r.slow_distance};
      REG_STOP_DIST: prdata = {16'd0, cfg_r.stop_distance};
      REG_HEAD_TOL:  prdata = {17'd0, cfg_r.heading_tolerance};
      REG_GAIN:      prdata = {20'd0, cfg_r.steering_gain};
      default:       prdata = '0;
    endcase
  end

endmodule

[design/gtg_dp.sv]
// gtg_dp: datapath. Goal offset, iterative vectoring CORDIC for bearing,
// one shared 18x18 multiplier for gain and squared distances, decision logic.
// Depends on gtg_pkg; driven by gtg_ctrl through gtg_cmd_t.
module gtg_dp import gtg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  gtg_cfg_t           cfg,
  input  gtg_cmd_t           cmd,
  input  logic signed [15:0] pose_x,
  input  logic signed [15:0] pose_y,
  input  logic signed [15:0] pose_heading,
  output logic signed [15:0] linear_velocity,
  output logic signed [15:0] angular_velocity,
  output logic               arrived
);

  // Captured request and CORDIC state
  logic signed [OFS_W-1:0]  dx_r, dy_r;
  logic signed [15:0]       heading_r;
  logic                     zero_r;
  logic signed [XY_W-1:0]   x_r, y_r;
  logic signed [Z_W-1:0]    z_r;
  logic signed [ERR_W-1:0]  err_r;

  // Multiplier and products
  logic signed [MUL_W-1:0]      op_a, op_b;
  logic signed [PROD_W-1:0]     prod_r;
  mul_sel_t                     sel_d_r;
  logic                         store_r;
  logic signed [ANG_PROD_W-1:0] ang_prod_r;
  logic [D2_W-1:0]              d2_r;
  logic [SQ_W-1:0]              stop2_r, slow2_r;

  // Result registers
  logic                     goal_reached_r;
  logic signed [15:0]       lin_r, ang_r;

  logic signed [XY_W-1:0]   x_pre, y_pre, x_sh, y_sh;
  logic signed [Z_W-1:0]    z_step, z_rnd;
  logic signed [15:0]       bearing;
  logic [ERR_W-1:0]         abs_err;
  logic                     turn;
  logic signed [ANG_PROD_W-1:0] ang_rnd;
  logic signed [15:0]       ang_sat, lin_nxt, ang_nxt;
  logic                     arrive_now;

  // Offset scaled by 64 for the CORDIC
  assign x_pre  = {{(XY_W-OFS_W-6){dx_r[OFS_W-1]}}, dx_r, 6'b0};
  assign y_pre  = {{(XY_W-OFS_W-6){dy_r[OFS_W-1]}}, dy_r, 6'b0};
  assign x_sh   = x_r >>> cmd.iter_idx;
  assign y_sh   = y_r >>> cmd.iter_idx;
  assign z_step = {{(Z_W-20){1'b0}}, atan_q20(cmd.iter_idx)};

  // Bearing rounded from Q.20 to Q3.12
  assign z_rnd   = z_r + Z_W'(128);
  assign bearing = zero_r ? 16'sd0 : z_rnd[Z_W-1:8];

  // Offset capture, quadrant fold and vectoring steps
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      dx_r      <= OFS_W'(cfg.goal_x) - OFS_W'(pose_x);
      dy_r      <= OFS_W'(cfg.goal_y) - OFS_W'(pose_y);
      heading_r <= pose_heading;
    end
    if (cmd.pre_rot) begin
      zero_r <= (dx_r == '0) && (dy_r == '0);
      if (dx_r[OFS_W-1]) begin
        if (!dy_r[OFS_W-1]) begin
          x_r <= y_pre;
          y_r <= -x_pre;
          z_r <= HALF_PI_Q20;
        end else begin
          x_r <= -y_pre;
          y_r <= x_pre;
          z_r <= -HALF_PI_Q20;
        end
      end else begin
        x_r <= x_pre;
        y_r <= y_pre;
        z_r <= '0;
      end
    end else if (cmd.iter_en) begin
      if (!y_r[XY_W-1]) begin
        x_r <= x_r + y_sh;
        y_r <= y_r - x_sh;
        z_r <= z_r + z_step;
      end else begin
        x_r <= x_r - y_sh;
        y_r <= y_r + x_sh;
        z_r <= z_r - z_step;
      end
    end
    if (cmd.bear_en) begin
      err_r <= ERR_W'(bearing) - ERR_W'(heading_r);
    end
  end

  // Shared multiplier operand select
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_ERR: begin
        op_a = {{(MUL_W-12){1'b0}}, cfg.steering_gain};
        op_b = MUL_W'(err_r);
      end
      MUL_DX: begin
        op_a = MUL_W'(dx_r);
        op_b = MUL_W'(dx_r);
      end
      MUL_DY: begin
        op_a = MUL_W'(dy_r);
        op_b = MUL_W'(dy_r);
      end
      MUL_STOP: begin
        op_a = {{(MUL_W-16){1'b0}}, cfg.stop_distance};
        op_b = {{(MUL_W-16){1'b0}}, cfg.stop_distance};
      end
      MUL_SLOW: begin
        op_a = {{(MUL_W-16){1'b0}}, cfg.slow_distance};
        op_b = {{(MUL_W-16){1'b0}}, cfg.slow_distance};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Multiply, then file the product in the next cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r <= 1'b0;
    end else begin
      store_r <= cmd.mul_go;
    end
    if (cmd.mul_go) begin
      prod_r  <= op_a * op_b;
      sel_d_r <= cmd.mul_sel;
    end
    if (store_r) begin
      case (sel_d_r)
        MUL_ERR:  ang_prod_r <= prod_r[ANG_PROD_W-1:0];
        MUL_DX:   d2_r       <= {1'b0, prod_r[SQ_W-1:0]};
        MUL_DY:   d2_r       <= d2_r + {1'b0, prod_r[SQ_W-1:0]};
        MUL_STOP: stop2_r    <= prod_r[SQ_W-1:0];
        MUL_SLOW: slow2_r    <= prod_r[SQ_W-1:0];
        default: ;
      endcase
    end
  end

  // Decision: turn in place, drive, or arrive
  assign abs_err = err_r[ERR_W-1] ? ERR_W'(-err_r) : ERR_W'(err_r);
  assign turn    = abs_err > {{(ERR_W-15){1'b0}}, cfg.heading_tolerance};
  assign ang_rnd = (ang_prod_r + ANG_PROD_W'(512)) >>> 10;

  always_comb begin
    if (ang_rnd > ANG_PROD_W'(32767)) begin
      ang_sat = 16'sh7FFF;
    end else if (ang_rnd < -ANG_PROD_W'(32768)) begin
      ang_sat = -16'sh8000;
    end else begin
      ang_sat = ang_rnd[15:0];
    end
  end

  always_comb begin
    lin_nxt    = 16'sd0;
    ang_nxt    = 16'sd0;
    arrive_now = 1'b0;
    if (!goal_reached_r) begin
      if (turn) begin
        ang_nxt = ang_sat;
      end else if (d2_r >= {1'b0, stop2_r}) begin
        lin_nxt = (d2_r >= {1'b0, slow2_r}) ? cfg.cruise_speed : cfg.slow_speed;
      end else begin
        arrive_now = 1'b1;
      end
    end
  end

  // Result and sticky arrival flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_reached_r <= 1'b0;
    end else if (cmd.load_out) begin
      goal_reached_r <= goal_reached_r | arrive_now;
    end
    if (cmd.load_out) begin
      lin_r <= lin_nxt;
      ang_r <= ang_nxt;
    end
  end

  assign linear_velocity  = lin_r;
  assign angular_velocity = ang_r;
  assign arrived          = goal_reached_r;

endmodule

[design/gtg_ctrl.sv]
// gtg_ctrl: controller state machine. Sequences offset capture, CORDIC steps,
// bearing, five multiplies and the result handoff; owns the handshake flags.
// Depends on gtg_pkg for gtg_cmd_t.
module gtg_ctrl import gtg_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output gtg_cmd_t cmd
);

  localparam int CNT_W = $clog2(CORDIC_STEPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_ITER,
    ST_BEAR,
    ST_MUL,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] cnt_r;
  logic             in_ready_r;
  logic             out_valid_r;
  logic             accept;
  logic             out_free;

  assign accept    = in_valid & in_ready_r;
  assign out_free  = ~out_valid_r | out_ready;
  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

  // Commands decoded from state
  always_comb begin
    cmd          = '0;
    cmd.load_in  = accept;
    cmd.pre_rot  = (state_r == ST_PRE);
    cmd.iter_en  = (state_r == ST_ITER);
    cmd.iter_idx = ATAN_IDX_W'(cnt_r);
    cmd.bear_en  = (state_r == ST_BEAR);
    cmd.mul_go   = (state_r == ST_MUL);
    cmd.mul_sel  = mul_sel_t'(cnt_r[2:0]);
    cmd.load_out = (state_r == ST_FINISH) & out_free;
  end

  // State, counter and handshake flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      // Result flag: set on handoff, cleared once taken
      if ((state_r == ST_FINISH) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            in_ready_r <= 1'b0;
            state_r    <= ST_PRE;
          end
        end
        ST_PRE: begin
          cnt_r   <= '0;
          state_r <= ST_ITER;
        end
        ST_ITER: begin
          if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) begin
            state_r <= ST_BEAR;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_BEAR: begin
          cnt_r   <= '0;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          if (cnt_r[2:0] == 3'(MUL_SLOW)) begin
            state_r <= ST_DRAIN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          state_r <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            in_ready_r  <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[design/go_to_goal_velocity_controller.sv]
// Go-to-goal velocity controller, top level.
// Usage:
//   in_ch  : pose request (pose_x, pose_y Q6.10; pose_heading Q3.12 rad),
//            valid/ready, accepted when both are high at a clock edge.
//   out_ch : one command per request (linear_velocity, angular_velocity
//            Q6.10, sticky arrived flag), valid/ready.
//   psel/penable/pwrite/paddr/pwdata/prdata/pready: APB-style register port,
//            register i at byte address 4*i; write only while idle.
// Timing: one request at a time. The interval between accepted requests is
//   set by the iterative CORDIC (one vectoring step per cycle) followed by
//   five passes through the shared 18x18 multiplier. The result becomes
//   valid, and in_ready rises again, at the same clock edge.
// A finished result sits in the output register; in_ready rises again at the
//   same time, so a new request can be taken while the result waits. If the
//   receiver still holds off when the next result is done, that result waits
//   internally until the output register frees.
// Reset (rst_n low, synchronous) clears the arrived flag, the handshake state
//   and loads the register defaults.
// Depends on gtg_pkg, gtg_if, gtg_regs, gtg_ctrl, gtg_dp.
module go_to_goal_velocity_controller import gtg_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  gtg_in_if.sink                in_ch,
  gtg_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  gtg_cfg_t           cfg;
  gtg_cmd_t           cmd;
  logic               in_ready;
  logic               out_valid;
  logic signed [15:0] lin, ang;
  logic               arr;

  // Configuration registers
  gtg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer
  gtg_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // Arithmetic
  gtg_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .pose_x           (in_ch.pose_x),
    .pose_y           (in_ch.pose_y),
    .pose_heading     (in_ch.pose_heading),
    .linear_velocity  (lin),
    .angular_velocity (ang),
    .arrived          (arr)
  );

  assign in_ch.ready             = in_ready;
  assign out_ch.valid            = out_valid;
  assign out_ch.linear_velocity  = lin;
  assign out_ch.angular_velocity = ang;
  assign out_ch.arrived          = arr;

endmodule

[design/gtg_checker.sv]
// gtg_checker: port-level assertions for the go-to-goal controller, bound
// to the top level below. Depends on nothing but the top level's ports.
module gtg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] linear_velocity,
  input logic [15:0] angular_velocity,
  input logic        arrived
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(linear_velocity) && $stable(angular_velocity)
      && $stable(arrived))
    else $error("result payload changed while stalled");

  // One request in flight: ready drops right after a request is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  // Once arrived, the command is a full stop
  a_arrived_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && arrived |-> linear_velocity == 16'd0 && angular_velocity == 16'd0)
    else $error("motion commanded after arrival");

  // Never drive and turn at once
  a_drive_or_turn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && linear_velocity != 16'd0 |-> angular_velocity == 16'd0)
    else $error("linear and angular commands both nonzero");

endmodule

bind go_to_goal_velocity_controller gtg_checker u_gtg_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .linear_velocity  (out_ch.linear_velocity),
  .angular_velocity (out_ch.angular_velocity),
  .arrived          (out_ch.arrived)
);
